### sv/jtag_sequence_engine_macros.svh
// assertion macros shared by the jtag sequence engine rtl
// no dependencies; included by the files that carry assertions
`ifndef JTAG_SEQUENCE_ENGINE_MACROS_SVH
`define JTAG_SEQUENCE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define JSE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define JSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSE_ASSERT(lbl, clk, rstn, prop, msg)
`define JSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/jse_pkg.sv
// types and constants of the jtag sequence engine
// no dependencies; imported by jse_parser, jse_emitter and the top level
package jse_pkg;

    // request header byte fields
    localparam logic [7:0] HDR_BITS    = 8'h3F;
    localparam logic [7:0] HDR_TMS     = 8'h40;
    localparam logic [7:0] HDR_CAPTURE = 8'h80;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // result kinds
    localparam logic KIND_CLOCK = 1'b0;
    localparam logic KIND_RESP  = 1'b1;

    // work left by one input byte, handed from parser to emitter
    typedef struct packed {
        logic       pair;     // echo + status pair instead of bit clocks
        logic [3:0] nbits;    // bit clocks to issue, 1..8
        logic       tms;      // tms level for all clocks
        logic [7:0] tdi;      // tdi bits, lsb first
        logic       capture;  // append captured tdo byte
        logic [7:0] resp;     // echoed command or captured tdo bits
    } bundle_t;

    // one result transaction
    typedef struct packed {
        logic       kind;
        logic       tms;
        logic       tdi;
        logic [7:0] resp;
        logic       last;
    } result_t;

endpackage

### sv/jse_parser.sv
// request parser: tracks the request phase and turns each count and data byte into a bundle
// depends on jse_pkg and jtag_sequence_engine_macros.svh
`include "jtag_sequence_engine_macros.svh"

module jse_parser import jse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte, [15:8] tdo_levels
    output bundle_t              bnd,
    output logic                 bnd_valid,
    input  logic                 bnd_take
);

    typedef enum logic [1:0] {
        PH_CMD,
        PH_COUNT,
        PH_HEADER,
        PH_DATA
    } phase_t;

    phase_t     phase_reg,     phase_next;
    logic [7:0] cmd_echo_reg,  cmd_echo_next;
    logic [7:0] seq_left_reg,  seq_left_next;
    logic [6:0] bits_left_reg, bits_left_next;
    logic       tms_reg,       tms_next;
    logic       cap_reg,       cap_next;
    bundle_t    bnd_reg,       bnd_next;
    logic       bnd_valid_reg, bnd_valid_next;

    logic [7:0] rx_byte;
    logic [7:0] tdo_levels;
    logic       accept;
    logic [3:0] n_bits;
    logic [7:0] cap_mask;
    logic [6:0] bits_rem;
    logic [7:0] seq_dec;
    logic [5:0] hdr_cnt;

    assign rx_byte    = s_tdata[7:0];
    assign tdo_levels = s_tdata[15:8];
    assign s_tready   = !bnd_valid_reg || bnd_take;
    assign accept     = s_tvalid && s_tready;
    assign bnd        = bnd_reg;
    assign bnd_valid  = bnd_valid_reg;

    // bits clocked by this data byte
    always_comb begin
        if (bits_left_reg == 7'd0) begin
            n_bits = 4'd1;
        end else if (bits_left_reg > 7'd8) begin
            n_bits = 4'd8;
        end else begin
            n_bits = bits_left_reg[3:0];
        end
        for (int j = 0; j < 8; j++) begin
            cap_mask[j] = (4'(j) < n_bits);
        end
        bits_rem = (bits_left_reg > {3'b000, n_bits}) ?
                   (bits_left_reg - {3'b000, n_bits}) : 7'd0;
        seq_dec  = seq_left_reg - 8'd1;
        hdr_cnt  = (rx_byte[5:0] & HDR_BITS[5:0]) - 6'd1;
    end

    // phase sequencing and bundle build
    always_comb begin
        phase_next     = phase_reg;
        cmd_echo_next  = cmd_echo_reg;
        seq_left_next  = seq_left_reg;
        bits_left_next = bits_left_reg;
        tms_next       = tms_reg;
        cap_next       = cap_reg;
        bnd_next       = bnd_reg;
        bnd_valid_next = bnd_valid_reg && !bnd_take;
        if (accept) begin
            unique case (phase_reg)
                PH_CMD: begin
                    cmd_echo_next = rx_byte;
                    phase_next    = PH_COUNT;
                end
                PH_COUNT: begin
                    bnd_next.pair    = 1'b1;
                    bnd_next.nbits   = 4'd2;
                    bnd_next.tms     = 1'b0;
                    bnd_next.tdi     = 8'h00;
                    bnd_next.capture = 1'b0;
                    bnd_next.resp    = cmd_echo_reg;
                    bnd_valid_next   = 1'b1;
                    seq_left_next    = rx_byte;
                    phase_next       = (rx_byte == 8'd0) ? PH_CMD : PH_HEADER;
                end
                PH_HEADER: begin
                    tms_next       = |(rx_byte & HDR_TMS);
                    cap_next       = |(rx_byte & HDR_CAPTURE);
                    bits_left_next = {1'b0, hdr_cnt} + 7'd1;
                    phase_next     = PH_DATA;
                end
                PH_DATA: begin
                    bnd_next.pair    = 1'b0;
                    bnd_next.nbits   = n_bits;
                    bnd_next.tms     = tms_reg;
                    bnd_next.tdi     = rx_byte;
                    bnd_next.capture = cap_reg;
                    bnd_next.resp    = tdo_levels & cap_mask;
                    bnd_valid_next   = 1'b1;
                    bits_left_next   = bits_rem;
                    if (bits_rem == 7'd0) begin
                        seq_left_next = seq_dec;
                        phase_next    = (seq_dec == 8'd0) ? PH_CMD : PH_HEADER;
                    end
                end
                default: begin
                    phase_next = PH_CMD;
                end
            endcase
        end
    end

    // state and bundle registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CMD;
            cmd_echo_reg  <= 8'd0;
            seq_left_reg  <= 8'd0;
            bits_left_reg <= 7'd0;
            tms_reg       <= 1'b0;
            cap_reg       <= 1'b0;
            bnd_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            cmd_echo_reg  <= cmd_echo_next;
            seq_left_reg  <= seq_left_next;
            bits_left_reg <= bits_left_next;
            tms_reg       <= tms_next;
            cap_reg       <= cap_next;
            bnd_valid_reg <= bnd_valid_next;
        end
        bnd_reg <= bnd_next;
    end

    // a data phase always has bits outstanding
    `JSE_ASSERT(a_data_has_bits, aclk, aresetn, (phase_reg == PH_DATA) |-> (bits_left_reg != 7'd0), "data phase with no bits left")
    // a held bundle blocks new input unless it is taken
    `JSE_ASSERT(a_hold_blocks, aclk, aresetn, (bnd_valid_reg && !bnd_take) |-> !s_tready, "input taken over a held bundle")

endmodule

### sv/jse_emitter.sv
// result emitter: walks one bundle and issues one result transaction per cycle while m_tready does not stall the output
// depends on jse_pkg and jtag_sequence_engine_macros.svh
`include "jtag_sequence_engine_macros.svh"

module jse_emitter import jse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bundle_t              bnd,
    input  logic                 bnd_valid,
    output logic                 bnd_take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] tms_level, [1] tdi_level, [9:2] resp_byte
    output logic                 m_tuser,   // [0] kind
    output logic                 m_tlast    // last
);

    bundle_t    cur_reg,       cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [3:0] idx_reg,       idx_next;
    logic       m_tvalid_reg,  m_tvalid_next;
    result_t    res_reg,       res_next;

    result_t    res;
    logic [3:0] res_count;
    logic       out_free;
    logic       step;
    logic       fin;

    // result selected by the walk index
    always_comb begin
        res.kind = KIND_RESP;
        res.tms  = 1'b0;
        res.tdi  = 1'b0;
        res.resp = 8'h00;
        res.last = 1'b0;
        if (cur_reg.pair) begin
            res.resp = idx_reg[0] ? 8'h00 : cur_reg.resp;
            res.last = idx_reg[0];
        end else if (idx_reg < cur_reg.nbits) begin
            res.kind = KIND_CLOCK;
            res.tms  = cur_reg.tms;
            res.tdi  = cur_reg.tdi[idx_reg[2:0]];
            res.last = (idx_reg == (cur_reg.nbits - 4'd1)) && !cur_reg.capture;
        end else begin
            res.resp = cur_reg.resp;
            res.last = 1'b1;
        end
        res_count = cur_reg.pair ? 4'd2 : (cur_reg.nbits + {3'b000, cur_reg.capture});
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign step     = cur_valid_reg && out_free;
    assign fin      = step && res.last;
    assign bnd_take = !cur_valid_reg || fin;

    // walk and output register control
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        res_next       = res_reg;
        if (out_free) begin
            m_tvalid_next = step;
        end
        if (step) begin
            res_next = res;
            idx_next = idx_reg + 4'd1;
        end
        if (bnd_take) begin
            cur_valid_next = bnd_valid;
            if (bnd_valid) begin
                cur_next = bnd;
                idx_next = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg.resp, res_reg.tdi, res_reg.tms};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

    // walk never runs past the results of its bundle
    `JSE_ASSERT(a_idx_in_range, aclk, aresetn, cur_valid_reg |-> (idx_reg < res_count), "walk index past bundle")
    // a bundle that is taken starts its walk at the first result
    `JSE_ASSERT(a_load_restarts, aclk, aresetn, (bnd_take && bnd_valid) |=> (cur_valid_reg && (idx_reg == 4'd0)), "bundle load did not restart walk")
    // no result leaves in the cycle after reset
    `JSE_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid_reg, "output valid after reset")

endmodule

### sv/jtag_sequence_engine.sv
// JTAG sequence engine: takes one request byte per transaction (with the TDO levels
// sampled for that byte) and issues bit clock and response byte transactions. Command
// and header bytes produce nothing; the count byte produces the echoed command and a
// zero status; a data byte produces one clock transaction per bit it carries plus,
// when capturing, the captured TDO byte, so n transactions, or n + 1 when capturing,
// at most nine. The single result register sets the rate: one result transaction per
// cycle while m_tready does not stall the output, and the next input byte is taken
// while results of the previous one are still going out.
// depends on jse_pkg, jse_parser and jse_emitter
module jtag_sequence_engine import jse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte, [15:8] tdo_levels
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] tms_level, [1] tdi_level, [9:2] resp_byte
    output logic                 m_tuser,   // [0] kind
    output logic                 m_tlast    // last
);

    bundle_t bnd;
    logic    bnd_valid;
    logic    bnd_take;

    // phase tracking and bundle build
    jse_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .bnd       (bnd),
        .bnd_valid (bnd_valid),
        .bnd_take  (bnd_take)
    );

    // result serialization
    jse_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bnd       (bnd),
        .bnd_valid (bnd_valid),
        .bnd_take  (bnd_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### test/testbench.sv
// self-checking testbench for jtag_sequence_engine: streams request bytes, predicts the
// bit clock and response transactions, and checks each one as it leaves the block
// depends on jse_pkg and jtag_sequence_engine
module testbench;
    import jse_pkg::*;

    // parse position of the request stream
    typedef enum logic [1:0] {
        WAIT_CMD,
        WAIT_COUNT,
        WAIT_HEADER,
        WAIT_DATA
    } parse_phase_t;

    // one request byte waiting to be sent
    typedef struct {
        logic [7:0]  rx;
        logic [7:0]  tdo;
        int unsigned gap;     // idle cycles before this byte is offered
        bit          drain;   // hold until every expected result has come
    } req_byte_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;     // [7:0] rx_byte, [15:8] tdo_levels
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;           // [0] tms_level, [1] tdi_level, [9:2] resp_byte
    logic                 m_tuser;           // [0] kind
    logic                 m_tlast;

    req_byte_t   req_bytes[$];
    result_t     expected_results[$];
    int unsigned error_count = 0;

    // predictor state
    parse_phase_t parse_phase  = WAIT_CMD;
    logic [7:0]   echo_byte    = 8'h00;
    logic [7:0]   seqs_left    = 8'h00;
    logic [6:0]   bits_left    = 7'd0;
    logic         tms_level    = 1'b0;
    logic         capture_on   = 1'b0;

    // sender and receiver pacing
    int unsigned tx_wait       = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_calm_left  = 0;

    jtag_sequence_engine u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // mostly short idle gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // mostly short shifts, some up to the full 64 bits
    function automatic int unsigned pick_bits();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(1, 16);
        if (r < 90)
            return $urandom_range(17, 40);
        return $urandom_range(41, 64);
    endfunction

    function automatic result_t make_result(logic kind, logic tms, logic tdi,
                                            logic [7:0] resp, logic last);
        result_t r;
        r.kind = kind;
        r.tms  = tms;
        r.tdi  = tdi;
        r.resp = resp;
        r.last = last;
        return r;
    endfunction

    // expected transactions for one accepted request byte
    task automatic predict_transactions(input logic [7:0] rx, input logic [7:0] tdo);
        logic [7:0]  dec;
        logic [7:0]  mask;
        int unsigned n;
        case (parse_phase)
            WAIT_CMD: begin
                echo_byte   = rx;
                parse_phase = WAIT_COUNT;
            end
            WAIT_COUNT: begin
                expected_results.push_back(make_result(KIND_RESP, 1'b0, 1'b0, echo_byte, 1'b0));
                expected_results.push_back(make_result(KIND_RESP, 1'b0, 1'b0, 8'h00, 1'b1));
                seqs_left   = rx;
                parse_phase = (rx == 8'h00) ? WAIT_CMD : WAIT_HEADER;
            end
            WAIT_HEADER: begin
                tms_level   = (rx & HDR_TMS) != 8'h00;
                capture_on  = (rx & HDR_CAPTURE) != 8'h00;
                // count field holds the bit count modulo 64, so zero means 64
                dec         = (rx - 8'd1) & HDR_BITS;
                bits_left   = dec[6:0] + 7'd1;
                parse_phase = WAIT_DATA;
            end
            WAIT_DATA: begin
                n = (bits_left > 7'd8) ? 8 : bits_left;
                for (int i = 0; i < n; i++)
                    expected_results.push_back(make_result(KIND_CLOCK, tms_level, rx[i], 8'h00,
                                                           (i == n - 1) && !capture_on));
                // tdo bits past the clocked ones read as zero
                mask = 8'hFF >> (8 - n);
                if (capture_on)
                    expected_results.push_back(make_result(KIND_RESP, 1'b0, 1'b0, tdo & mask,
                                                           1'b1));
                bits_left = bits_left - n[6:0];
                if (bits_left == 7'd0) begin
                    seqs_left   = seqs_left - 8'd1;
                    parse_phase = (seqs_left == 8'h00) ? WAIT_CMD : WAIT_HEADER;
                end
            end
        endcase
    endtask

    task automatic add_byte(input logic [7:0] rx, input logic [7:0] tdo,
                            input int unsigned gap, input bit drain);
        req_byte_t b;
        b.rx    = rx;
        b.tdo   = tdo;
        b.gap   = gap;
        b.drain = drain;
        req_bytes.push_back(b);
    endtask

    // header plus random tdi and tdo bytes for one sequence
    task automatic add_sequence(input int unsigned nbits, input bit calm);
        logic [5:0] code;
        code = 6'(nbits);
        add_byte({1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), code},
                 8'($urandom_range(0, 255)), calm ? 0 : pick_gap(), 1'b0);
        for (int i = 0; i < (nbits + 7) / 8; i++)
            add_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     calm ? 0 : pick_gap(), 1'b0);
    endtask

    // sender: offers queued request bytes, predicts on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_transactions(s_tdata[7:0], s_tdata[15:8]);
            if (!s_tvalid || s_tready) begin
                if (req_bytes.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (req_bytes[0].drain && expected_results.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (tx_wait < req_bytes[0].gap) begin
                    tx_wait  = tx_wait + 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= {req_bytes[0].tdo, req_bytes[0].rx};
                    s_tvalid <= 1'b1;
                    tx_wait  = 0;
                    void'(req_bytes.pop_front());
                end
            end
        end
    end

    // receiver: random back-pressure, compares each result transaction
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = make_result(m_tuser, m_tdata[0], m_tdata[1], m_tdata[9:2], m_tlast);
                if (expected_results.size() == 0) begin
                    error_count = error_count + 1;
                    $display("%0t: unexpected result kind=%b tms=%b tdi=%b resp=%h last=%b",
                             $time, got.kind, got.tms, got.tdi, got.resp, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.tms !== want.tms ||
                        got.tdi !== want.tdi || got.resp !== want.resp ||
                        got.last !== want.last) begin
                        error_count = error_count + 1;
                        $display("%0t: expected kind=%b tms=%b tdi=%b resp=%h last=%b",
                                 $time, want.kind, want.tms, want.tdi, want.resp, want.last);
                        $display("%0t: actual   kind=%b tms=%b tdi=%b resp=%h last=%b",
                                 $time, got.kind, got.tms, got.tdi, got.resp, got.last);
                    end
                end
            end
            // occasional stretches without any stall
            if (rx_calm_left > 0)
                rx_calm_left = rx_calm_left - 1;
            else if ($urandom_range(0, 299) == 0)
                rx_calm_left = $urandom_range(30, 150);
            if (rx_stall_left > 0) begin
                rx_stall_left = rx_stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (rx_calm_left == 0 && $urandom_range(0, 3) == 0)
                    rx_stall_left = pick_gap();
            end
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned nseq;
        int unsigned target;
        bit          calm;
        bit          first;

        // zero sequence count with an all-ones command
        add_byte(8'hFF, 8'h00, 0, 1'b0);
        add_byte(8'h00, 8'hFF, 0, 1'b0);
        // three sequences: full byte captured, partial byte captured, 64 bits plain
        add_byte(8'h00, 8'h00, 0, 1'b0);
        add_byte(8'h03, 8'h00, 1, 1'b0);
        add_byte(8'hC8, 8'h00, 0, 1'b0);
        add_byte(8'hFF, 8'hFF, 0, 1'b0);
        add_byte(8'h84, 8'h00, 2, 1'b0);
        add_byte(8'hFF, 8'hFF, 0, 1'b0);
        add_byte(8'h00, 8'h00, 0, 1'b0);
        add_byte(8'h00, 8'hFF, 0, 1'b0);
        add_byte(8'hFF, 8'h00, 0, 1'b0);
        add_byte(8'h55, 8'hAA, 3, 1'b0);
        add_byte(8'hAA, 8'h55, 0, 1'b0);
        add_byte(8'h01, 8'h80, 0, 1'b0);
        add_byte(8'h80, 8'h01, 0, 1'b0);
        add_byte(8'h0F, 8'hF0, 0, 1'b0);
        add_byte(8'hF0, 8'h0F, 0, 1'b0);
        // two sequences: nine bits captured, the second byte carrying a single bit, then one bit plain
        add_byte(8'h5A, 8'h00, 0, 1'b0);
        add_byte(8'h02, 8'h00, 0, 1'b0);
        add_byte(8'hC9, 8'h00, 0, 1'b0);
        add_byte(8'h3C, 8'hA5, 0, 1'b0);
        add_byte(8'hFF, 8'hFE, 0, 1'b0);
        add_byte(8'h41, 8'h00, 0, 1'b0);
        add_byte(8'h02, 8'hFF, 0, 1'b0);

        // well-formed requests with random content
        target = req_bytes.size() + 90;
        first  = 1'b1;
        while (req_bytes.size() < target) begin
            calm = ($urandom_range(0, 4) == 0);
            nseq = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
            add_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     calm ? 0 : pick_gap(), first || ($urandom_range(0, 5) == 0));
            add_byte(8'(nseq), 8'($urandom_range(0, 255)), calm ? 0 : pick_gap(), 1'b0);
            repeat (nseq) add_sequence(pick_bits(), calm);
            first = 1'b0;
        end

        // broken request at the end: large count, cut off after two sequences
        add_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_gap(), 1'b1);
        add_byte(8'($urandom_range(128, 255)), 8'($urandom_range(0, 255)), pick_gap(), 1'b0);
        add_sequence(pick_bits(), 1'b0);
        add_sequence(pick_bits(), 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        wait (req_bytes.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("jtag_sequence_engine: match");
        else
            $display("jtag_sequence_engine: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("jtag_sequence_engine: mismatch");
        $finish;
    end

endmodule
